@@ rtl/nps_pkg.sv @@
package nps_pkg;

   localparam int PATTERN_MAX_DEFAULT = 8;
   localparam int QUEUE_DEPTH         = 2;
   localparam int INDEX_WIDTH         = 32;
   localparam int CSR_INDEX_WIDTH     = 8;
   localparam int CSR_DATA_WIDTH      = 64;
   localparam int LENGTH_WIDTH        = 4;
   localparam int COUNT_WIDTH         = 16;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      REG_PATTERN_BYTES    = 8'd0,
      REG_PATTERN_SIZE     = 8'd1,
      REG_OCCURRENCE_COUNT = 8'd2,
      REG_START_POSITION   = 8'd3
   } csr_reg_type;

   typedef struct packed {
      logic [63:0]              pattern_bytes;
      logic [LENGTH_WIDTH-1:0]  pattern_size;
      logic [COUNT_WIDTH-1:0]   occurrence_count;
      logic [INDEX_WIDTH-1:0]   start_position;
   } cfg_type;

   typedef struct packed {
      logic                    eos;
      logic [INDEX_WIDTH-1:0]  match_first;
      logic [INDEX_WIDTH-1:0]  match_end;
   } cand_type;

   typedef struct packed {
      logic                    found;
      logic [INDEX_WIDTH-1:0]  match_first;
      logic [INDEX_WIDTH-1:0]  match_end;
   } result_type;

endpackage

@@ rtl/nth_pattern_occurrence_search.sv @@
// Path: a result reaches the rsp ports through the front compare, the queue, the
// back count and the output register; the back holds items while a result waits.
// Throughput: one item per cycle while full is low, set by the combinational
// parallel window compare and a two-entry queue between front and back.
// Reset: synchronous, clears window, counters, queue, rsp valid; no clearing pass.
module nth_pattern_occurrence_search import nps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   output logic                       full,
   input  logic [7:0]                 req_byte_value,
   input  logic [INDEX_WIDTH-1:0]     req_byte_index,
   input  logic                       req_end_of_stream,
   output logic                       empty,
   input  logic                       pop,
   output logic                       rsp_found,
   output logic [INDEX_WIDTH-1:0]     rsp_match_first,
   output logic [INDEX_WIDTH-1:0]     rsp_match_end,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data
);

   cfg_type    cfg;
   logic       restart;
   logic       accept;
   logic       cand_push;
   cand_type   cand, head;
   logic       q_full, q_empty, head_pop;
   result_type result;

   assign full   = q_full;
   assign accept = push && !q_full;

   nps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg),
      .restart   (restart)
   );

   nps_front #(.PATTERN_MAX(PATTERN_MAX)) u_front (
      .clock         (clock),
      .reset         (reset),
      .restart       (restart),
      .cfg           (cfg),
      .accept        (accept),
      .byte_value    (req_byte_value),
      .byte_index    (req_byte_index),
      .end_of_stream (req_end_of_stream),
      .cand_push     (cand_push),
      .cand          (cand)
   );

   nps_fifo #(.WIDTH($bits(cand_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .clear     (restart),
      .push      (cand_push),
      .push_data (cand),
      .full      (q_full),
      .pop       (head_pop),
      .pop_data  (head),
      .empty     (q_empty)
   );

   nps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .restart    (restart),
      .cfg        (cfg),
      .head_valid (!q_empty),
      .head       (head),
      .head_pop   (head_pop),
      .rsp_pop    (pop),
      .rsp_empty  (empty),
      .result     (result)
   );

   assign rsp_found       = result.found;
   assign rsp_match_first = result.match_first;
   assign rsp_match_end   = result.match_end;

endmodule

@@ rtl/nps_csr.sv @@
module nps_csr import nps_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_data,
   output cfg_type                    cfg,
   output logic                       restart
);

   cfg_type cfg_ff, cfg_in;
   logic    restart_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in     = cfg_ff;
      restart_in = 1'b0;
      if (csr_valid) begin
         restart_in = 1'b1;
         case (csr_index)
            REG_PATTERN_BYTES:    cfg_in.pattern_bytes    = csr_data;
            REG_PATTERN_SIZE:     cfg_in.pattern_size     = csr_data[LENGTH_WIDTH-1:0];
            REG_OCCURRENCE_COUNT: cfg_in.occurrence_count = csr_data[COUNT_WIDTH-1:0];
            REG_START_POSITION:   cfg_in.start_position   = csr_data[INDEX_WIDTH-1:0];
            default:              restart_in = 1'b0;
         endcase
      end
   end

   assign restart = restart_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_bytes    <= '0;
         cfg_ff.pattern_size     <= LENGTH_WIDTH'(1);
         cfg_ff.occurrence_count <= COUNT_WIDTH'(1);
         cfg_ff.start_position   <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

@@ rtl/nps_fifo.sv @@
module nps_fifo import nps_pkg::*; #(
   parameter int WIDTH = 1,
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             clear,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

@@ rtl/nps_front.sv @@
module nps_front import nps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   restart,
   input  cfg_type                cfg,
   input  logic                   accept,
   input  logic [7:0]             byte_value,
   input  logic [INDEX_WIDTH-1:0] byte_index,
   input  logic                   end_of_stream,
   output logic                   cand_push,
   output cand_type               cand
);

   localparam int WIN_W  = 8 * PATTERN_MAX;
   localparam int FILL_W = $clog2(PATTERN_MAX + 1);

   logic [WIN_W-1:0]        window_ff, window_in, base_window, shifted_window;
   logic [FILL_W-1:0]       fill_ff, fill_in, base_fill, shifted_fill;
   logic [INDEX_WIDTH-1:0]  expected_ff, expected_in;
   logic [LENGTH_WIDTH-1:0] used_len;
   logic [PATTERN_MAX:1]    len_match;
   logic                    gap, in_range, pattern_hit, fill_ok;
   logic [INDEX_WIDTH-1:0]  first_idx;

   always_comb begin
      if (cfg.pattern_size == '0) begin
         used_len = LENGTH_WIDTH'(1);
      end else if (cfg.pattern_size > LENGTH_WIDTH'(PATTERN_MAX)) begin
         used_len = LENGTH_WIDTH'(PATTERN_MAX);
      end else begin
         used_len = cfg.pattern_size;
      end
   end

   assign gap            = (byte_index != expected_ff);
   assign base_window    = gap ? '0 : window_ff;
   assign base_fill      = gap ? '0 : fill_ff;
   assign in_range       = (byte_index >= cfg.start_position);
   assign shifted_window = (base_window << 8) | WIN_W'(byte_value);
   assign shifted_fill   = (base_fill < FILL_W'(PATTERN_MAX)) ? base_fill + FILL_W'(1)
                                                              : base_fill;

   always_comb begin
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         len_match[l] = 1'b1;
         for (int i = 0; i < l; i++) begin
            if (shifted_window[8*(l-1-i) +: 8] != cfg.pattern_bytes[8*i +: 8]) begin
               len_match[l] = 1'b0;
            end
         end
      end
      pattern_hit = 1'b0;
      for (int l = 1; l <= PATTERN_MAX; l++) begin
         if (used_len == LENGTH_WIDTH'(l)) begin
            pattern_hit = len_match[l];
         end
      end
   end

   assign fill_ok   = (LENGTH_WIDTH'(shifted_fill) >= used_len);
   assign first_idx = byte_index - INDEX_WIDTH'(used_len - LENGTH_WIDTH'(1));

   always_comb begin
      window_in   = window_ff;
      fill_in     = fill_ff;
      expected_in = expected_ff;
      if (accept && !end_of_stream) begin
         expected_in = byte_index + INDEX_WIDTH'(1);
         if (in_range) begin
            window_in = shifted_window;
            fill_in   = shifted_fill;
         end else begin
            window_in = base_window;
            fill_in   = base_fill;
         end
      end
   end

   assign cand_push = accept && (end_of_stream ||
                      (in_range && fill_ok && pattern_hit &&
                       first_idx >= cfg.start_position));
   assign cand.eos         = end_of_stream;
   assign cand.match_first = first_idx;
   assign cand.match_end   = byte_index + INDEX_WIDTH'(1);

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         window_ff   <= '0;
         fill_ff     <= '0;
         expected_ff <= '0;
      end else begin
         window_ff   <= window_in;
         fill_ff     <= fill_in;
         expected_ff <= expected_in;
      end
   end

endmodule

@@ rtl/nps_back.sv @@
module nps_back import nps_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       restart,
   input  cfg_type    cfg,
   input  logic       head_valid,
   input  cand_type   head,
   output logic       head_pop,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output result_type result
);

   logic                   out_valid_ff, out_valid_in;
   result_type             out_ff, out_in;
   logic                   done_ff, done_in;
   logic [COUNT_WIDTH-1:0] matches_ff, matches_in, target;
   logic [INDEX_WIDTH-1:0] earliest_ff, earliest_in;
   logic [COUNT_WIDTH:0]   next_count;
   logic                   take, emit;

   assign target     = (cfg.occurrence_count == '0) ? COUNT_WIDTH'(1) : cfg.occurrence_count;
   assign next_count = {1'b0, matches_ff} + (COUNT_WIDTH + 1)'(1);
   assign take       = head_valid && (!out_valid_ff || rsp_pop);
   assign head_pop   = take;

   always_comb begin
      out_in      = out_ff;
      done_in     = done_ff;
      matches_in  = matches_ff;
      earliest_in = earliest_ff;
      emit        = 1'b0;
      if (take && !done_ff) begin
         if (head.eos) begin
            emit    = 1'b1;
            done_in = 1'b1;
            out_in  = '0;
         end else if (head.match_first >= earliest_ff) begin
            if (next_count >= {1'b0, target}) begin
               emit               = 1'b1;
               done_in            = 1'b1;
               out_in.found       = 1'b1;
               out_in.match_first = head.match_first;
               out_in.match_end   = head.match_end;
            end else begin
               matches_in  = next_count[COUNT_WIDTH-1:0];
               earliest_in = head.match_end;
            end
         end
      end
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (rsp_pop) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign result    = out_ff;

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         out_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
         matches_ff   <= '0;
         earliest_ff  <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         done_ff      <= done_in;
         matches_ff   <= matches_in;
         earliest_ff  <= earliest_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

endmodule

@@ rtl/nps_checker.sv @@
module nps_checker import nps_pkg::*; #(
   parameter int PATTERN_MAX = PATTERN_MAX_DEFAULT
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   full,
   input logic                   empty,
   input logic                   pop,
   input logic                   rsp_found,
   input logic [INDEX_WIDTH-1:0] rsp_match_first,
   input logic [INDEX_WIDTH-1:0] rsp_match_end
);

   logic [INDEX_WIDTH-1:0] span;

   assign span = rsp_match_end - rsp_match_first;

   a_reset_empty: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not clear after reset");

   a_not_found_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && !rsp_found) |-> (rsp_match_first == '0 && rsp_match_end == '0))
      else $error("not-found item carries nonzero indices");

   a_span: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_found) |-> (span != '0 && span <= INDEX_WIDTH'(PATTERN_MAX)))
      else $error("match span outside pattern length range");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_found) && $stable(rsp_match_first)))
      else $error("waiting item changed");

endmodule

bind nth_pattern_occurrence_search nps_checker #(.PATTERN_MAX(PATTERN_MAX)) u_checker (
   .clock           (clock),
   .reset           (reset),
   .full            (full),
   .empty           (empty),
   .pop             (pop),
   .rsp_found       (rsp_found),
   .rsp_match_first (rsp_match_first),
   .rsp_match_end   (rsp_match_end)
);
